// ===== rtl/vertex_weld_dedup_assert.svh =====
// Assertion macros used by the probe unit (vwd_probe.sv).
// They sample on clk and are disabled while arst_n is low.
`ifndef VERTEX_WELD_DEDUP_ASSERT_SVH
`define VERTEX_WELD_DEDUP_ASSERT_SVH
`ifndef SYNTHESIS
`define VWD_ASSERT(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
	else $error("vertex weld check failed");
`define VWD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("vertex weld sequence check failed");
`else
`define VWD_ASSERT(lbl, expr)
`define VWD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/vwd_pkg.sv =====
package vwd_pkg;
	localparam int MAX_VERTICES = 4096;
	localparam int HASH_SLOTS   = 8192;
	localparam int SLOT_W       = $clog2(HASH_SLOTS);
	localparam int CNT_W        = $clog2(MAX_VERTICES) + 1;
	localparam int IDX_W        = 12;
	localparam int COORD_W      = 32;
	localparam int EPOCH_W      = 8;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [63:0] HASH_C1 = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] HASH_C2 = 64'hC2B2AE3D27D4EB4F;
	localparam logic [63:0] HASH_C3 = 64'hBF58476D1CE4E5B9;

	typedef struct packed {
		logic               first;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic [SLOT_W-1:0]  slot;
	} req_t;

	typedef struct packed {
		logic               overflow;
		logic [COORD_W-1:0] z;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] x;
		logic               is_new;
		logic [IDX_W-1:0]   index;
	} result_t;

	// negative zero compares equal to positive zero
	function automatic logic [COORD_W-1:0] fold_zero(input logic [COORD_W-1:0] v);
		fold_zero = (v == {1'b1, {(COORD_W-1){1'b0}}}) ? '0 : v;
	endfunction
endpackage

// ===== rtl/vertex_weld_dedup.sv =====
// Vertex welding by hash-table deduplication.
// Input stream: s_tdata carries one position (x, y, z float bit patterns),
// s_tuser marks the first vertex of a mesh and empties the table first.
// Output stream: one result per vertex, in input order: the compact index,
// a new-vertex flag with the position copied out, and an overflow flag.
// A front unit hashes each position with one shared 32x32 multiplier;
// a two-entry queue feeds the probe unit, which takes a request in
// ST_IDLE and then, per probed slot, does a registered table read
// (ST_READ) and then a compare (ST_CHECK). The front unit takes a new
// vertex only once it has pushed the last one; throughput is set by the
// hash unit while probe chains stay short, else by the probe unit.
// After reset the probe unit clears the 8192-entry epoch table, one entry
// a cycle; requests queue up and stall until then. The same sweep runs
// when the 8-bit mesh epoch wraps on a new mesh.
// When m_tready is low the result is held in the output register; hashing
// and the queue keep going until the queue fills, then s_tready stays low.
module vertex_weld_dedup (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,  // pos_x, pos_y, pos_z
	input  logic         s_tuser,  // first_of_mesh
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [111:0] m_tdata   // merged_index, is_new, new_x, new_y, new_z, overflow
);
	import vwd_pkg::*;

	req_t    push_data, pop_data;
	logic    push_valid, push_ready, pop_valid, pop_ready;
	result_t res;

	vwd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	vwd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push_valid),
		.in_ready  (push_ready),
		.in_data   (push_data),
		.out_valid (pop_valid),
		.out_ready (pop_ready),
		.out_data  (pop_data)
	);

	vwd_probe u_probe (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (pop_valid),
		.req_ready (pop_ready),
		.req       (pop_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (res)
	);

	assign m_tdata = {2'b00, res};
endmodule

// ===== rtl/vwd_front.sv =====
module vwd_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [95:0]    s_tdata,
	input  logic           s_tuser,
	output logic           push_valid,
	input  logic           push_ready,
	output vwd_pkg::req_t  push_data
);
	import vwd_pkg::*;

	localparam logic [3:0] STEP_LAST = 4'd11;

	logic                busy_q;
	logic [3:0]          step_q;
	logic                first_q;
	logic [COORD_W-1:0]  x_q, y_q, z_q;
	logic [63:0]         prod_q, acc_q, m2_q, g_q;
	logic [31:0]         mul_a, mul_b;
	logic [63:0]         h1;
	logic [COORD_W-1:0]  fx, fy, fz;

	assign fx = fold_zero(x_q);
	assign fy = fold_zero(y_q);
	assign fz = fold_zero(z_q);
	assign h1 = acc_q ^ m2_q;

	// one 32x32 multiplier, shared over the three 64-bit products
	always_comb begin
		case (step_q)
			4'd0: begin mul_a = fy;         mul_b = HASH_C1[31:0];  end
			4'd1: begin mul_a = fy;         mul_b = HASH_C1[63:32]; end
			4'd2: begin mul_a = fx;         mul_b = HASH_C1[31:0];  end
			4'd3: begin mul_a = fz;         mul_b = HASH_C2[31:0];  end
			4'd4: begin mul_a = fz;         mul_b = HASH_C2[63:32]; end
			4'd7: begin mul_a = g_q[31:0];  mul_b = HASH_C3[31:0];  end
			4'd8: begin mul_a = g_q[31:0];  mul_b = HASH_C3[63:32]; end
			4'd9: begin mul_a = g_q[63:32]; mul_b = HASH_C3[31:0];  end
			default: begin mul_a = '0;      mul_b = '0;             end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (!busy_q) begin
			if (s_tvalid) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end
		end else if (step_q != STEP_LAST) begin
			step_q <= step_q + 4'd1;
		end else if (push_ready) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && s_tvalid) begin
			first_q <= s_tuser;
			x_q     <= s_tdata[31:0];
			y_q     <= s_tdata[63:32];
			z_q     <= s_tdata[95:64];
		end
		prod_q <= {32'd0, mul_a} * {32'd0, mul_b};
		if (busy_q) begin
			case (step_q)
				4'd1, 4'd8: acc_q <= prod_q;
				4'd2, 4'd3, 4'd9, 4'd10: acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
				4'd4: m2_q <= prod_q;
				4'd5: m2_q[63:32] <= m2_q[63:32] + prod_q[31:0];
				4'd6: g_q <= h1 ^ (h1 >> 29);
				default: ;
			endcase
		end
	end

	assign s_tready        = !busy_q;
	assign push_valid      = busy_q && (step_q == STEP_LAST);
	assign push_data.first = first_q;
	assign push_data.x     = x_q;
	assign push_data.y     = y_q;
	assign push_data.z     = z_q;
	assign push_data.slot  = acc_q[SLOT_W-1:0] ^ acc_q[SLOT_W+31:32];
endmodule

// ===== rtl/vwd_queue.sv =====
module vwd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  vwd_pkg::req_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output vwd_pkg::req_t out_data
);
	import vwd_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

	req_t              mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_QW-1:0] count_q;
	logic              push, pop;

	assign in_ready  = count_q != CNT_QW'(QUEUE_DEPTH);
	assign out_valid = count_q != '0;
	assign out_data  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= in_data;
	end
endmodule

// ===== rtl/vwd_probe.sv =====
module vwd_probe (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  vwd_pkg::req_t    req,
	output logic             out_valid,
	input  logic             out_ready,
	output vwd_pkg::result_t out_data
);
	import vwd_pkg::*;

	typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_CHECK} state_t;

	typedef struct packed {
		logic [63:0]        xy;
		logic [COORD_W-1:0] z;
		logic [IDX_W-1:0]   index;
	} entry_t;

	entry_t             ent_mem [HASH_SLOTS];
	logic [EPOCH_W-1:0] ep_mem  [HASH_SLOTS];

	state_t             state_q;
	logic [EPOCH_W-1:0] cur_epoch_q, ep_rd_q;
	entry_t             ent_rd_q;
	logic [CNT_W-1:0]   count_q;
	logic [SLOT_W-1:0]  clr_q, slot_q, probes_q;
	logic               resume_q;
	logic               out_valid_q;
	result_t            out_q;
	result_t            res_d;
	logic [63:0]        kxy_q;
	logic [COORD_W-1:0] kz_q, x_q, y_q, z_q;

	logic emit_ok, free, hit, last_probe, full, done, wr_en, rd_en, emit;

	assign emit_ok    = !out_valid_q || out_ready;
	assign free       = ep_rd_q != cur_epoch_q;
	assign hit        = !free && (ent_rd_q.xy == kxy_q) && (ent_rd_q.z == kz_q);
	assign last_probe = probes_q == SLOT_W'(HASH_SLOTS - 1);
	assign full       = count_q >= CNT_W'(MAX_VERTICES);
	assign done       = free || hit || last_probe;
	assign emit       = (state_q == ST_CHECK) && done && emit_ok;
	assign wr_en      = (state_q == ST_CHECK) && emit_ok && free && !full;
	assign rd_en      = state_q == ST_READ;
	assign req_ready  = state_q == ST_IDLE;
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;

	always_comb begin
		res_d = '0;
		if (hit) begin
			res_d.index = ent_rd_q.index;
		end else if (free && !full) begin
			res_d.index  = count_q[IDX_W-1:0];
			res_d.is_new = 1'b1;
			res_d.x      = x_q;
			res_d.y      = y_q;
			res_d.z      = z_q;
		end else begin
			res_d.overflow = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			ent_rd_q <= ent_mem[slot_q];
			ep_rd_q  <= ep_mem[slot_q];
		end
		if (wr_en)
			ent_mem[slot_q] <= '{xy: kxy_q, z: kz_q, index: count_q[IDX_W-1:0]};
		if (state_q == ST_CLEAR)
			ep_mem[clr_q] <= '0;
		else if (wr_en)
			ep_mem[slot_q] <= cur_epoch_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cur_epoch_q <= EPOCH_W'(1);
			count_q     <= '0;
			clr_q       <= '0;
			resume_q    <= 1'b0;
			slot_q      <= '0;
			probes_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SLOT_W'(HASH_SLOTS - 1)) begin
						state_q  <= resume_q ? ST_READ : ST_IDLE;
						resume_q <= 1'b0;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						slot_q   <= req.slot;
						probes_q <= '0;
						if (req.first) begin
							count_q <= '0;
							// epoch wraps: wipe the tags before probing
							if (cur_epoch_q == '1) begin
								cur_epoch_q <= EPOCH_W'(1);
								clr_q       <= '0;
								resume_q    <= 1'b1;
								state_q     <= ST_CLEAR;
							end else begin
								cur_epoch_q <= cur_epoch_q + 1'b1;
								state_q     <= ST_READ;
							end
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: state_q <= ST_CHECK;
				ST_CHECK: begin
					if (!done) begin
						slot_q   <= (slot_q == SLOT_W'(HASH_SLOTS - 1)) ? '0 : slot_q + 1'b1;
						probes_q <= probes_q + 1'b1;
						state_q  <= ST_READ;
					end else if (emit_ok) begin
						state_q <= ST_IDLE;
						if (wr_en)
							count_q <= count_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			kxy_q <= {fold_zero(req.x), fold_zero(req.y)};
			kz_q  <= fold_zero(req.z);
			x_q   <= req.x;
			y_q   <= req.y;
			z_q   <= req.z;
		end
		if (emit)
			out_q <= res_d;
	end

`include "vertex_weld_dedup_assert.svh"
	`VWD_ASSERT(a_count_max, count_q <= CNT_W'(MAX_VERTICES))
	`VWD_ASSERT(a_epoch_nonzero, cur_epoch_q != '0)
	`VWD_ASSERT(a_new_not_ovf, !(out_valid_q && out_q.is_new && out_q.overflow))
	`VWD_ASSERT_NEXT(a_append_counts, wr_en, count_q == CNT_W'($past(count_q) + 1'b1))
endmodule
